[hdl/mcbp_pkg.sv]
// Shared package for the motor command byte parser.
// Holds the channel payload types, command codes and default constants.
// No dependencies; the core and the testbench refer to it.
`timescale 1ns / 1ps
`default_nettype none

package mcbp_pkg;

  // Default length of the speed table and the start byte after reset
  localparam int unsigned ForwardLenDefault = 32;
  localparam logic [7:0]  StartByteReset    = 8'd85;

  // Number of bytes in the gain reply (code, P gain, I gain)
  localparam int unsigned ReplyPiLen = 3;

  // Item kinds on the input channel
  localparam logic OP_RX_BYTE  = 1'b0;
  localparam logic OP_TX_READY = 1'b1;

  // Command codes
  localparam logic [7:0] CMD_SAVE       = 8'd1;
  localparam logic [7:0] CMD_LOAD       = 8'd2;
  localparam logic [7:0] CMD_SEND_PI    = 8'd3;
  localparam logic [7:0] CMD_RECV_PI    = 8'd4;
  localparam logic [7:0] CMD_RECV_TABLE = 8'd5;
  localparam logic [7:0] CMD_SET_PWM    = 8'd6;
  localparam logic [7:0] CMD_SET_RPM    = 8'd7;
  localparam logic [7:0] CMD_SEND_TABLE = 8'd8;
  localparam logic [7:0] CMD_SAMPLE     = 8'd9;
  localparam logic [7:0] CMD_CLEAR      = 8'd10;

  // Input item: received byte or transmitter-ready event
  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        save_pulse;
    logic        load_pulse;
    logic        sample_pulse;
    logic        pwm_override_on;
    logic [7:0]  pwm_override_value;
    logic        rpm_override_on;
    logic [15:0] rpm_override_value;
    logic [7:0]  gain_p_out;
    logic [7:0]  gain_i_out;
    logic        reply_busy;
  } out_item_t;

  // Configuration write data (start byte)
  typedef logic [7:0] cfg_item_t;

endpackage

`default_nettype wire

[hdl/mcbp_stream_if.sv]
// Valid/ready channel interface used for input, result and configuration.
// The payload type is a parameter; types come from mcbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mcbp_stream_if #(
  parameter type T = logic [7:0]
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/mcbp_out_buf.sv]
// Two-entry result buffer: decouples the result channel from the parse stage.
// Its ready depends only on the count register, so no combinational path runs from out ready back.
// Depends on mcbp_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module mcbp_out_buf #(
  parameter type T = logic [7:0]
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push_valid,
  output logic          push_ready,
  input  wire T         push_data,
  mcbp_stream_if.source out_if
);

  localparam logic [1:0] DEPTH = 2'd2;

  T           buf_mem [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       push, pop;

  assign push_ready   = (cnt_r != DEPTH);
  assign out_if.valid = (cnt_r != 2'd0);
  assign out_if.data  = buf_mem[rd_ptr_r];

  assign push = push_valid && push_ready;
  assign pop  = out_if.valid && out_if.ready;

  // Occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[hdl/motor_command_byte_parser_core.sv]
// Motor command byte parser: takes received bytes and transmit-ready events,
// one per transfer, and returns exactly one result per input transfer. The
// block accepts one input transfer every clock cycle as long as the result side
// keeps up; each result passes through one parse stage register, then a
// two-entry output buffer, before it is presented on the output. Speed-table
// reads go through a synchronous memory port registered in the parse stage;
// each table entry has a valid bit cleared by reset, so no clearing pass is
// needed after reset. The start byte is written through the configuration
// channel, which is always ready. Depends on mcbp_pkg, mcbp_stream_if and
// mcbp_out_buf.
`timescale 1ns / 1ps
`default_nettype none

module motor_command_byte_parser_core #(
  parameter int unsigned FORWARD_LEN = mcbp_pkg::ForwardLenDefault
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  mcbp_stream_if.sink   in_if,
  mcbp_stream_if.source out_if,
  mcbp_stream_if.sink   cfg_if
);

  // Widths derived from the table length
  localparam int unsigned TBL_AW  = (FORWARD_LEN > 1) ? $clog2(FORWARD_LEN) : 1;
  localparam int unsigned POS_MAX = (FORWARD_LEN > mcbp_pkg::ReplyPiLen) ?
                                    FORWARD_LEN : mcbp_pkg::ReplyPiLen;
  localparam int unsigned POS_W   = $clog2(POS_MAX + 1);
  localparam int unsigned CNT_W   = $clog2(FORWARD_LEN + 1);

  localparam logic [POS_W-1:0] TBL_LEN_POS   = POS_W'(FORWARD_LEN);
  localparam logic [POS_W-1:0] PI_LEN_POS    = POS_W'(mcbp_pkg::ReplyPiLen);
  localparam logic [CNT_W-1:0] TBL_LEN_CNT   = CNT_W'(FORWARD_LEN);

  // Parser phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_ARMED = 3'd1;
  localparam logic [2:0] PH_GAINS = 3'd2;
  localparam logic [2:0] PH_TABLE = 3'd3;
  localparam logic [2:0] PH_PWM   = 3'd4;
  localparam logic [2:0] PH_RPM   = 3'd5;

  // Configuration
  logic [7:0] start_byte_r;

  // Parser and reply state
  logic [2:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             sending_r, sending_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             from_tbl_r, from_tbl_nxt;
  logic [7:0]       words_r [3];
  logic [7:0]       words_nxt [3];
  logic [7:0]       gain_p_r, gain_p_nxt;
  logic [7:0]       gain_i_r, gain_i_nxt;
  logic [7:0]       pwm_r, pwm_nxt;
  logic [15:0]      rpm_r, rpm_nxt;
  logic             pwm_on_r, pwm_on_nxt;
  logic             rpm_on_r, rpm_on_nxt;

  // Speed table memory with per-entry valid bits
  logic [7:0]             tbl_mem [FORWARD_LEN];
  logic [FORWARD_LEN-1:0] tbl_vld_r;
  logic                   tbl_we;
  logic [TBL_AW-1:0]      tbl_waddr;
  logic [TBL_AW-1:0]      tbl_raddr;
  logic [7:0]             tbl_q_r;
  logic                   tbl_q_vld_r;

  // Parse stage
  logic                s1_valid_r;
  mcbp_pkg::out_item_t s1_item_r;
  logic                s1_tbl_sel_r;
  mcbp_pkg::out_item_t res;
  logic                res_tbl_sel;
  mcbp_pkg::out_item_t push_item;
  logic                buf_ready;
  logic                s1_push;

  logic       in_acc;
  logic       op;
  logic [7:0] rx_b;
  logic [POS_W-1:0] send_len;

  assign op       = in_if.data.opcode;
  assign rx_b     = in_if.data.rx_byte;
  assign s1_push  = s1_valid_r && buf_ready;
  assign in_if.ready = !s1_valid_r || buf_ready;
  assign in_acc   = in_if.valid && in_if.ready;
  assign send_len = from_tbl_r ? TBL_LEN_POS : PI_LEN_POS;
  assign tbl_waddr = cnt_r[TBL_AW-1:0];
  assign tbl_raddr = pos_r[TBL_AW-1:0];

  // Configuration write
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= mcbp_pkg::StartByteReset;
    end else if (cfg_if.valid) begin
      start_byte_r <= cfg_if.data;
    end
  end

  // Next state and result for the accepted item
  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    sending_nxt  = sending_r;
    pos_nxt      = pos_r;
    from_tbl_nxt = from_tbl_r;
    words_nxt    = words_r;
    gain_p_nxt   = gain_p_r;
    gain_i_nxt   = gain_i_r;
    pwm_nxt      = pwm_r;
    rpm_nxt      = rpm_r;
    pwm_on_nxt   = pwm_on_r;
    rpm_on_nxt   = rpm_on_r;
    tbl_we       = 1'b0;
    res_tbl_sel  = 1'b0;
    res          = '0;

    if (in_acc) begin
      if (op == mcbp_pkg::OP_TX_READY) begin
        // Reply transmitter asks for the next byte
        if (sending_r) begin
          if (pos_r < send_len) begin
            res.tx_valid = 1'b1;
            if (from_tbl_r) begin
              res_tbl_sel = 1'b1;
            end else begin
              res.tx_byte = words_r[pos_r[1:0]];
            end
            pos_nxt = pos_r + 1'b1;
          end else begin
            sending_nxt = 1'b0;
          end
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            if (rx_b == start_byte_r) begin
              phase_nxt = PH_ARMED;
            end
          end
          PH_ARMED: begin
            phase_nxt = PH_IDLE;
            unique case (rx_b)
              mcbp_pkg::CMD_SAVE:   res.save_pulse = 1'b1;
              mcbp_pkg::CMD_LOAD:   res.load_pulse = 1'b1;
              mcbp_pkg::CMD_SEND_PI: begin
                if (!sending_r) begin
                  words_nxt[0] = mcbp_pkg::CMD_SEND_PI;
                  words_nxt[1] = gain_p_r;
                  words_nxt[2] = gain_i_r;
                  from_tbl_nxt = 1'b0;
                  pos_nxt      = '0;
                  sending_nxt  = 1'b1;
                end
              end
              mcbp_pkg::CMD_RECV_PI: begin
                phase_nxt = PH_GAINS;
                cnt_nxt   = '0;
              end
              mcbp_pkg::CMD_RECV_TABLE: begin
                phase_nxt = PH_TABLE;
                cnt_nxt   = '0;
              end
              mcbp_pkg::CMD_SET_PWM: begin
                phase_nxt = PH_PWM;
                cnt_nxt   = '0;
              end
              mcbp_pkg::CMD_SET_RPM: begin
                phase_nxt = PH_RPM;
                cnt_nxt   = '0;
              end
              mcbp_pkg::CMD_SEND_TABLE: begin
                if (!sending_r) begin
                  from_tbl_nxt = 1'b1;
                  pos_nxt      = '0;
                  sending_nxt  = 1'b1;
                end
              end
              mcbp_pkg::CMD_SAMPLE: res.sample_pulse = 1'b1;
              mcbp_pkg::CMD_CLEAR: begin
                pwm_on_nxt = 1'b0;
                rpm_on_nxt = 1'b0;
              end
              default: ;
            endcase
          end
          PH_GAINS: begin
            if (cnt_r == '0) begin
              gain_p_nxt = rx_b;
            end else begin
              if (cnt_r == CNT_W'(1)) begin
                gain_i_nxt = rx_b;
              end
              phase_nxt = PH_IDLE;
            end
            cnt_nxt = cnt_r + 1'b1;
          end
          PH_TABLE: begin
            // The byte after the last table entry is dropped
            if (cnt_r < TBL_LEN_CNT) begin
              tbl_we  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_PWM: begin
            if (cnt_r == '0) begin
              pwm_nxt    = rx_b;
              pwm_on_nxt = 1'b1;
              rpm_on_nxt = 1'b0;
            end
            phase_nxt = PH_IDLE;
            cnt_nxt   = cnt_r + 1'b1;
          end
          PH_RPM: begin
            // High byte first; low byte completes the value
            if (cnt_r == '0) begin
              rpm_on_nxt = 1'b0;
              pwm_on_nxt = 1'b0;
              rpm_nxt    = {rx_b, 8'h00};
            end else begin
              if (cnt_r == CNT_W'(1)) begin
                rpm_nxt    = {rpm_r[15:8], rx_b};
                rpm_on_nxt = 1'b1;
              end
              phase_nxt = PH_IDLE;
            end
            cnt_nxt = cnt_r + 1'b1;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end

    // Status fields show the state after the item
    res.pwm_override_on    = pwm_on_nxt;
    res.pwm_override_value = pwm_nxt;
    res.rpm_override_on    = rpm_on_nxt;
    res.rpm_override_value = rpm_nxt;
    res.gain_p_out         = gain_p_nxt;
    res.gain_i_out         = gain_i_nxt;
    res.reply_busy         = sending_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      cnt_r      <= '0;
      sending_r  <= 1'b0;
      pos_r      <= '0;
      from_tbl_r <= 1'b0;
      words_r    <= '{default: 8'h00};
      gain_p_r   <= 8'h00;
      gain_i_r   <= 8'h00;
      pwm_r      <= 8'h00;
      rpm_r      <= 16'h0000;
      pwm_on_r   <= 1'b0;
      rpm_on_r   <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      sending_r  <= sending_nxt;
      pos_r      <= pos_nxt;
      from_tbl_r <= from_tbl_nxt;
      words_r    <= words_nxt;
      gain_p_r   <= gain_p_nxt;
      gain_i_r   <= gain_i_nxt;
      pwm_r      <= pwm_nxt;
      rpm_r      <= rpm_nxt;
      pwm_on_r   <= pwm_on_nxt;
      rpm_on_r   <= rpm_on_nxt;
    end
  end

  // Speed table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= rx_b;
    end
    if (in_acc) begin
      tbl_q_r <= tbl_mem[tbl_raddr];
    end
  end

  // Entry valid bits; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r   <= '0;
      tbl_q_vld_r <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_vld_r[tbl_waddr] <= 1'b1;
      end
      if (in_acc) begin
        tbl_q_vld_r <= tbl_vld_r[tbl_raddr];
      end
    end
  end

  // Parse stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_push) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r    <= res;
      s1_tbl_sel_r <= res_tbl_sel;
    end
  end

  // Merge the table read data into the result
  always_comb begin
    push_item = s1_item_r;
    if (s1_tbl_sel_r) begin
      push_item.tx_byte = tbl_q_vld_r ? tbl_q_r : 8'h00;
    end
  end

  mcbp_out_buf #(
    .T (mcbp_pkg::out_item_t)
  ) u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (s1_valid_r),
    .push_ready (buf_ready),
    .push_data  (push_item),
    .out_if     (out_if)
  );

`ifndef SYNTHESIS
  // The two overrides are never active together
  a_override_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(pwm_on_r && rpm_on_r))
    else $error("pwm and rpm overrides both active");

  // Reply position never runs past the reply length
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sending_r |-> (pos_r <= send_len))
    else $error("reply position beyond reply length");

  // Table fill count stays within the table
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TABLE) |-> (cnt_r <= TBL_LEN_CNT))
    else $error("table fill count out of range");

  // At most one request pulse per result
  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $onehot0({s1_item_r.save_pulse, s1_item_r.load_pulse,
                             s1_item_r.sample_pulse}))
    else $error("more than one request pulse in a result");

  // An emitted reply byte leaves the reply still in progress
  a_tx_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_item_r.tx_valid) |-> s1_item_r.reply_busy)
    else $error("reply byte emitted while reply not busy");

  // A table byte is only selected for an emitted byte
  a_tbl_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_tbl_sel_r) |-> s1_item_r.tx_valid)
    else $error("table byte selected without tx_valid");
`endif

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for motor_command_byte_parser_core.
// Drives command bytes and transmit-ready events, predicts every result in a
// cycle-free model. Depends on mcbp_pkg, mcbp_stream_if and the core RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TABLE_LEN  = mcbp_pkg::ForwardLenDefault;
  localparam int unsigned STALL_LIMIT = 1000;

  // Parser phases of the predictor
  localparam logic [3:0] PARSE_IDLE  = 4'd0;
  localparam logic [3:0] PARSE_ARMED = 4'd1;
  localparam logic [3:0] PARSE_GAINS = 4'd2;
  localparam logic [3:0] PARSE_TABLE = 4'd3;
  localparam logic [3:0] PARSE_PWM   = 4'd4;
  localparam logic [3:0] PARSE_RPM   = 4'd5;

  // One row of the directed stimulus; want is used only when typed is set
  typedef struct {
    mcbp_pkg::in_item_t  item;
    bit                  typed;
    mcbp_pkg::out_item_t want;
  } dir_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  mcbp_stream_if #(.T(mcbp_pkg::in_item_t))  in_ch ();
  mcbp_stream_if #(.T(mcbp_pkg::out_item_t)) out_ch ();
  mcbp_stream_if #(.T(mcbp_pkg::cfg_item_t)) cfg_ch ();

  motor_command_byte_parser_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source),
    .cfg_if (cfg_ch.sink)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Parser model state
  logic [7:0]   arm_byte       = mcbp_pkg::StartByteReset;
  logic [3:0]   parse_state    = PARSE_IDLE;
  logic [7:0]   payload_cnt    = '0;
  logic         reply_active   = 1'b0;
  logic [7:0]   reply_pos      = '0;
  logic [7:0]   reply_len      = '0;
  logic         reply_from_tab = 1'b0;
  logic [7:0]   pi_reply  [mcbp_pkg::ReplyPiLen] = '{default: '0};
  logic [7:0]   speed_tab [TABLE_LEN]  = '{default: '0};
  logic [7:0]   gain_p_q       = '0;
  logic [7:0]   gain_i_q       = '0;
  logic [7:0]   pwm_val        = '0;
  logic [15:0]  rpm_val        = '0;
  logic         pwm_on         = 1'b0;
  logic         rpm_on         = 1'b0;

  mcbp_pkg::out_item_t parser_results_due [$];
  mcbp_pkg::in_item_t  stim_q [$];
  dir_row_t     dir_rows [$];
  bit           row_typed = 1'b0;
  mcbp_pkg::out_item_t row_want  = '0;
  bit           steady    = 1'b0;
  int unsigned  gap_calm  = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  fail_count  = 0;

  // Advance the parser model by one input transfer and return its result
  function automatic mcbp_pkg::out_item_t next_parser_result(mcbp_pkg::in_item_t it);
    mcbp_pkg::out_item_t r;
    logic [7:0] b;
    r = '0;
    b = it.rx_byte;
    if (it.opcode == mcbp_pkg::OP_TX_READY) begin
      if (reply_active) begin
        if (reply_pos < reply_len) begin
          r.tx_valid = 1'b1;
          // table bytes are read when emitted, not when the reply starts
          if (reply_from_tab)
            r.tx_byte = (reply_pos < TABLE_LEN) ? speed_tab[reply_pos] : 8'h00;
          else
            r.tx_byte = (reply_pos < mcbp_pkg::ReplyPiLen) ? pi_reply[reply_pos] : 8'h00;
          reply_pos = reply_pos + 8'd1;
        end else begin
          reply_active = 1'b0;
        end
      end
    end else begin
      case (parse_state)
        PARSE_IDLE: begin
          if (b == arm_byte) parse_state = PARSE_ARMED;
        end
        PARSE_ARMED: begin
          parse_state = PARSE_IDLE;
          case (b)
            mcbp_pkg::CMD_SAVE:   r.save_pulse = 1'b1;
            mcbp_pkg::CMD_LOAD:   r.load_pulse = 1'b1;
            mcbp_pkg::CMD_SAMPLE: r.sample_pulse = 1'b1;
            mcbp_pkg::CMD_SEND_PI: begin
              if (!reply_active) begin
                pi_reply[0]    = mcbp_pkg::CMD_SEND_PI;
                pi_reply[1]    = gain_p_q;
                pi_reply[2]    = gain_i_q;
                reply_len      = 8'(mcbp_pkg::ReplyPiLen);
                reply_from_tab = 1'b0;
                reply_pos      = '0;
                reply_active   = 1'b1;
              end
            end
            mcbp_pkg::CMD_SEND_TABLE: begin
              if (!reply_active) begin
                reply_len      = 8'(TABLE_LEN);
                reply_from_tab = 1'b1;
                reply_pos      = '0;
                reply_active   = 1'b1;
              end
            end
            mcbp_pkg::CMD_RECV_PI: begin
              parse_state = PARSE_GAINS;
              payload_cnt = '0;
            end
            mcbp_pkg::CMD_RECV_TABLE: begin
              parse_state = PARSE_TABLE;
              payload_cnt = '0;
            end
            mcbp_pkg::CMD_SET_PWM: begin
              parse_state = PARSE_PWM;
              payload_cnt = '0;
            end
            mcbp_pkg::CMD_SET_RPM: begin
              parse_state = PARSE_RPM;
              payload_cnt = '0;
            end
            mcbp_pkg::CMD_CLEAR: begin
              pwm_on = 1'b0;
              rpm_on = 1'b0;
            end
            default: ;
          endcase
        end
        PARSE_GAINS: begin
          if (payload_cnt == 0) begin
            gain_p_q = b;
          end else begin
            if (payload_cnt == 1) gain_i_q = b;
            parse_state = PARSE_IDLE;
          end
          payload_cnt = payload_cnt + 8'd1;
        end
        PARSE_TABLE: begin
          // the byte after the last table entry is swallowed
          if (payload_cnt < TABLE_LEN) begin
            speed_tab[payload_cnt] = b;
            payload_cnt = payload_cnt + 8'd1;
          end else begin
            parse_state = PARSE_IDLE;
          end
        end
        PARSE_PWM: begin
          if (payload_cnt == 0) begin
            pwm_val = b;
            pwm_on  = 1'b1;
            rpm_on  = 1'b0;
          end
          parse_state = PARSE_IDLE;
          payload_cnt = payload_cnt + 8'd1;
        end
        PARSE_RPM: begin
          // high byte drops both overrides, low byte completes the value
          if (payload_cnt == 0) begin
            rpm_on  = 1'b0;
            pwm_on  = 1'b0;
            rpm_val = {b, 8'h00};
          end else begin
            if (payload_cnt == 1) begin
              rpm_val = rpm_val + 16'(b);
              rpm_on  = 1'b1;
            end
            parse_state = PARSE_IDLE;
          end
          payload_cnt = payload_cnt + 8'd1;
        end
        default: parse_state = PARSE_IDLE;
      endcase
    end
    r.pwm_override_on    = pwm_on;
    r.pwm_override_value = pwm_val;
    r.rpm_override_on    = rpm_on;
    r.rpm_override_value = rpm_val;
    r.gain_p_out         = gain_p_q;
    r.gain_i_out         = gain_i_q;
    r.reply_busy         = reply_active;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Model update on input and config transfers, compare on result transfers
  always @(posedge clk) begin : result_check
    mcbp_pkg::out_item_t want;
    mcbp_pkg::out_item_t got;
    if (cfg_ch.valid && cfg_ch.ready) arm_byte = cfg_ch.data;
    if (in_ch.valid && in_ch.ready) begin
      want = next_parser_result(in_ch.data);
      if (row_typed) want = row_want;
      parser_results_due.push_back(want);
    end
    if (out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (parser_results_due.size() == 0) begin
        $error("result transfer with nothing expected: 0x%0h", got);
        fail_count++;
      end else begin
        want = parser_results_due.pop_front();
        compare_field("tx_valid", want.tx_valid, got.tx_valid);
        compare_field("tx_byte", want.tx_byte, got.tx_byte);
        compare_field("save_pulse", want.save_pulse, got.save_pulse);
        compare_field("load_pulse", want.load_pulse, got.load_pulse);
        compare_field("sample_pulse", want.sample_pulse, got.sample_pulse);
        compare_field("pwm_override_on", want.pwm_override_on, got.pwm_override_on);
        compare_field("pwm_override_value", want.pwm_override_value,
                      got.pwm_override_value);
        compare_field("rpm_override_on", want.rpm_override_on, got.rpm_override_on);
        compare_field("rpm_override_value", want.rpm_override_value,
                      got.rpm_override_value);
        compare_field("gain_p_out", want.gain_p_out, got.gain_p_out);
        compare_field("gain_i_out", want.gain_i_out, got.gain_i_out);
        compare_field("reply_busy", want.reply_busy, got.reply_busy);
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  // Result side: random stall bursts, calm stretches, none once steady
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned calm_left;
    stall_left = 0;
    calm_left  = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (calm_left > 0) begin
        calm_left--;
      end else begin
        case ($urandom_range(0, 15))
          0: stall_left = $urandom_range(1, 19);
          1: calm_left  = $urandom_range(20, 60);
          default: ;
        endcase
      end
      out_ch.ready <= steady || (stall_left == 0);
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(negedge clk);
    $display("motor_command_byte_parser_core verification failed");
    $finish;
  end

  function automatic mcbp_pkg::in_item_t rx_item(logic [7:0] b);
    return mcbp_pkg::in_item_t'{opcode: mcbp_pkg::OP_RX_BYTE, rx_byte: b};
  endfunction

  // Transmit-ready with a random, ignored byte field
  function automatic mcbp_pkg::in_item_t tx_ready_item();
    return mcbp_pkg::in_item_t'{opcode: mcbp_pkg::OP_TX_READY,
                                rx_byte: 8'($urandom_range(0, 255))};
  endfunction

  // Payload byte leaning toward the extremes
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_row(logic op, logic [7:0] b, bit typed, mcbp_pkg::out_item_t want);
    dir_row_t row;
    row.item  = mcbp_pkg::in_item_t'{opcode: op, rx_byte: b};
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // Mostly well-formed commands with random payload, plus noise and cut-off frames
  task automatic add_random_traffic(logic [7:0] arm);
    int unsigned pick;
    int unsigned len;
    logic [7:0]  code;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      stim_q.push_back(rx_item(rand_byte()));
    end else if (pick < 6) begin
      repeat ($urandom_range(1, 4)) stim_q.push_back(tx_ready_item());
    end else begin
      code = 8'($urandom_range(0, 10));
      if (code == 0) code = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(11, 255));
      stim_q.push_back(rx_item(arm));
      stim_q.push_back(rx_item(code));
      case (code) inside
        mcbp_pkg::CMD_RECV_PI, mcbp_pkg::CMD_SET_RPM: len = 2;
        mcbp_pkg::CMD_RECV_TABLE:                     len = TABLE_LEN + 1;
        mcbp_pkg::CMD_SET_PWM:                        len = 1;
        default:                                      len = 0;
      endcase
      if (len != 0 && $urandom_range(0, 7) == 0) len = $urandom_range(0, len - 1);
      repeat (len) stim_q.push_back(rx_item(rand_byte()));
      // drain a fresh reply at once half the time, else let it overlap later traffic
      if ((code == mcbp_pkg::CMD_SEND_PI || code == mcbp_pkg::CMD_SEND_TABLE) &&
          $urandom_range(0, 1))
        repeat (code == mcbp_pkg::CMD_SEND_PI ? mcbp_pkg::ReplyPiLen + 1 : TABLE_LEN + 1)
          stim_q.push_back(tx_ready_item());
    end
  endtask

  // One input transfer, with an optional idle burst ahead of it
  task automatic drive_item(mcbp_pkg::in_item_t it, bit typed, mcbp_pkg::out_item_t want);
    int unsigned gap;
    gap = 0;
    if (!steady) begin
      if (gap_calm > 0) begin
        gap_calm--;
      end else begin
        case ($urandom_range(0, 9))
          0: gap      = $urandom_range(1, 19);
          1: gap_calm = $urandom_range(10, 40);
          default: ;
        endcase
      end
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    row_typed = typed;
    row_want  = want;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_start_byte(mcbp_pkg::cfg_item_t value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    mcbp_pkg::out_item_t held;
    mcbp_pkg::cfg_item_t start_vals [4];
    int        ph;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames from reset, start byte at its reset value
    held = '{pwm_override_value: 8'hFF, rpm_override_value: 16'hFFFF,
             gain_p_out: 8'hFF, default: 0};
    add_row(mcbp_pkg::OP_TX_READY, 8'hFF, 1'b1, '{default: 0});
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::StartByteReset, 1'b1, '{default: 0});
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::CMD_SAVE, 1'b1,
            '{save_pulse: 1'b1, default: 0});
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::StartByteReset, 1'b0, '0);
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::CMD_LOAD, 1'b1,
            '{load_pulse: 1'b1, default: 0});
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::StartByteReset, 1'b0, '0);
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::CMD_SAMPLE, 1'b1,
            '{sample_pulse: 1'b1, default: 0});
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::StartByteReset, 1'b0, '0);
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::CMD_RECV_PI, 1'b0, '0);
    add_row(mcbp_pkg::OP_RX_BYTE, 8'hFF, 1'b0, '0);
    add_row(mcbp_pkg::OP_RX_BYTE, 8'h00, 1'b1, '{gain_p_out: 8'hFF, default: 0});
    // gain reply, with a table request ignored while it is sending
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::StartByteReset, 1'b0, '0);
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::CMD_SEND_PI, 1'b0, '0);
    add_row(mcbp_pkg::OP_TX_READY, 8'h00, 1'b0, '0);
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::StartByteReset, 1'b0, '0);
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::CMD_SEND_TABLE, 1'b0, '0);
    add_row(mcbp_pkg::OP_TX_READY, 8'h00, 1'b0, '0);
    add_row(mcbp_pkg::OP_TX_READY, 8'h00, 1'b0, '0);
    add_row(mcbp_pkg::OP_TX_READY, 8'h00, 1'b0, '0);
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::StartByteReset, 1'b0, '0);
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::CMD_SET_PWM, 1'b0, '0);
    add_row(mcbp_pkg::OP_RX_BYTE, 8'hFF, 1'b1,
            '{pwm_override_on: 1'b1, pwm_override_value: 8'hFF,
              gain_p_out: 8'hFF, default: 0});
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::StartByteReset, 1'b0, '0);
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::CMD_SET_RPM, 1'b0, '0);
    add_row(mcbp_pkg::OP_RX_BYTE, 8'hFF, 1'b0, '0);
    add_row(mcbp_pkg::OP_RX_BYTE, 8'hFF, 1'b1,
            '{pwm_override_value: 8'hFF, rpm_override_on: 1'b1,
              rpm_override_value: 16'hFFFF, gain_p_out: 8'hFF, default: 0});
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::StartByteReset, 1'b0, '0);
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::CMD_CLEAR, 1'b1, held);
    // unknown command code goes back to idle untouched
    add_row(mcbp_pkg::OP_RX_BYTE, mcbp_pkg::StartByteReset, 1'b0, '0);
    add_row(mcbp_pkg::OP_RX_BYTE, 8'hFF, 1'b1, held);

    foreach (dir_rows[i]) drive_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    in_ch.valid <= 1'b0;
    while (parser_results_due.size() != 0) @(negedge clk);

    // Random phases, each under its own start byte; the last one runs without idling
    start_vals[0] = 8'h00;
    start_vals[1] = 8'hFF;
    start_vals[2] = 8'($urandom_range(0, 255));
    start_vals[3] = mcbp_pkg::StartByteReset;
    for (ph = 0; ph < 4; ph++) begin
      write_start_byte(start_vals[ph]);
      while (stim_q.size() < 125) add_random_traffic(start_vals[ph]);
      steady = (ph == 3);
      while (stim_q.size() != 0) drive_item(stim_q.pop_front(), 1'b0, '0);
      in_ch.valid <= 1'b0;
      while (parser_results_due.size() != 0) @(negedge clk);
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("motor_command_byte_parser_core verification clean");
    end else begin
      $display("motor_command_byte_parser_core verification failed");
    end
    $finish;
  end

endmodule
